@@ sv/tkls_pkg.sv @@
package tkls_pkg;

    localparam int VALUE_W = 32;
    localparam int KEEP_W  = 5;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      set_end;
    } sample_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] kept_value;
        logic                      run_last;
    } result_t;

    typedef struct packed {
        logic                      ins;
        logic                      drop;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] cur_value;
        logic                      cur_valid;
        logic                      here;
        logic signed [VALUE_W-1:0] ins_value;
        logic                      ins_valid;
    } cell_link_t;

endpackage

@@ sv/top_k_largest_selector.sv @@
// Keeps the largest keep_count values of each set of signed 32-bit samples.
// Samples arrive as beats on the sample channel (valid/ready); set_end marks
// the final beat of a set. The kept values leave as beats on the result
// channel in ascending order, run_last high on the final beat of the run.
// keep_count is to be written through cfg_we/cfg_wdata while the block is
// idle; the block itself does not enforce this. Zero acts as one and values
// above MAX_KEEP act as MAX_KEEP. A row of MAX_KEEP cells holds the values
// sorted. Every sample beat is inserted in the cycle it is accepted, so the
// block takes one sample per cycle while a set is in progress. After a
// set_end beat the chain shifts one value per cycle into the result register
// while the receiver takes each beat: the set_end beat sets the drain flag,
// and each pop then loads the result register. During the run sample_ready is
// low; it rises in the cycle after the last value enters the result register.
// When the receiver stalls, the result register holds its beat and the
// chain waits. Reset empties the chain, clears the result valid flag and
// sets keep_count to 3.
module top_k_largest_selector
    import tkls_pkg::*;
#(
    parameter int MAX_KEEP = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_t           sample,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int EW = (CW > KEEP_W) ? CW : KEEP_W;

    logic [KEEP_W-1:0] keep_count_reg;
    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     total_next;
    logic              drain_reg;
    logic              drain_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    result_t           result_next;

    logic [EW-1:0]     keep_ext;
    logic [EW-1:0]     k_eff;
    logic              accept;
    logic              pop;
    logic              drop;
    cell_ctrl_t        ctrl;
    cell_link_t        link  [MAX_KEEP+1];
    cell_link_t        below [MAX_KEEP];
    logic [MAX_KEEP-1:0] valid_vec;

    assign keep_ext = EW'(keep_count_reg);

    always_comb
    begin
        if (keep_ext == '0)
        begin
            k_eff = EW'(1);
        end
        else if (keep_ext > EW'(MAX_KEEP))
        begin
            k_eff = EW'(MAX_KEEP);
        end
        else
        begin
            k_eff = keep_ext;
        end
    end

    assign sample_ready = !drain_reg;
    assign accept       = sample_valid && sample_ready;
    assign pop          = drain_reg && (!result_valid_reg || result_ready);
    assign drop         = EW'(total_reg) >= k_eff;

    assign ctrl.ins   = accept;
    assign ctrl.drop  = drop;
    assign ctrl.pop   = pop;
    assign ctrl.value = sample.sample_value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign below[gi] = '{cur_value: '0, cur_valid: 1'b1, here: 1'b0,
                                     ins_value: '0, ins_valid: 1'b1};
            end
            else
            begin : g_rest
                assign below[gi] = link[gi-1];
            end

            tkls_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .below (below[gi]),
                .above (link[gi+1]),
                .link  (link[gi])
            );

            assign valid_vec[gi] = link[gi].cur_valid;
        end
    endgenerate

    // Spare link above the top cell, with no storage: it supplies the overflow value of a full chain.
    assign link[MAX_KEEP] = '{cur_value: '0, cur_valid: 1'b0, here: 1'b1,
                              ins_value: link[MAX_KEEP-1].here ? link[MAX_KEEP-1].cur_value
                                                               : sample.sample_value,
                              ins_valid: link[MAX_KEEP-1].cur_valid};

    always_comb
    begin
        total_next        = total_reg;
        drain_next        = drain_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (!drop)
            begin
                total_next = total_reg + CW'(1);
            end
            drain_next = sample.set_end;
        end
        if (pop)
        begin
            result_valid_next      = 1'b1;
            result_next.kept_value = link[0].cur_value;
            result_next.run_last   = !link[1].cur_valid;
            total_next             = total_reg - CW'(1);
            if (!link[1].cur_valid)
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg   <= KEEP_W'(3);
            total_reg        <= '0;
            drain_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_count_reg <= cfg_wdata;
            end
            total_reg        <= total_next;
            drain_reg        <= drain_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(total_reg))
        else $error("Entry count disagrees with the cell valid bits.");

    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + MAX_KEEP'(1)) & valid_vec) == '0)
        else $error("Cell valid bits are not packed from the bottom.");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> link[0].cur_valid)
        else $error("Draining with an empty chain.");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !link[1].cur_valid |=> !drain_reg && total_reg == '0)
        else $error("Run did not end after its final beat.");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(total_reg) <= MAX_KEEP)
        else $error("Entry count exceeds the chain length.");

endmodule

@@ sv/tkls_cell.sv @@
module tkls_cell
    import tkls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t below,
    input  cell_link_t above,
    output cell_link_t link
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      greater;

    // The new value lands in the first cell holding a larger value or no value.
    assign greater = valid_reg && (value_reg > ctrl.value);

    always_comb
    begin
        link.cur_value = value_reg;
        link.cur_valid = valid_reg;
        link.here      = greater || !valid_reg;
        if (!link.here)
        begin
            link.ins_value = value_reg;
        end
        else if (below.here)
        begin
            link.ins_value = below.cur_value;
        end
        else
        begin
            link.ins_value = ctrl.value;
        end
        link.ins_valid = valid_reg || below.cur_valid;
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.pop)
        begin
            value_next = above.cur_value;
            valid_next = above.cur_valid;
        end
        else if (ctrl.ins)
        begin
            if (ctrl.drop)
            begin
                value_next = above.ins_value;
                valid_next = above.ins_valid;
            end
            else
            begin
                value_next = link.ins_value;
                valid_next = link.ins_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
